### hw/rtl/indexed_sequence_store_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed sequence store
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_STORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_ASSERT_SVH

// same-cycle implication
`define ISS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared widths, codes and types of the indexed sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

    localparam int DATA_W       = 32;
    localparam int MODE_W       = 3;
    localparam int POSA_W       = 7;
    localparam int POSB_W       = 6;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 7;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_HEAD = 3'd0,
        MODE_PUSH_TAIL = 3'd1,
        MODE_INSERT    = 3'd2,
        MODE_EXTRACT   = 3'd3,
        MODE_POP_HEAD  = 3'd4,
        MODE_POP_TAIL  = 3'd5,
        MODE_SWAP      = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EMPTY  = 2'd1,
        STATUS_FULL   = 2'd2,
        STATUS_BADIDX = 2'd3
    } status_t;

    // what one cell loads on the next edge
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOAD_A,
        CELL_LOAD_B
    } cell_op_t;

endpackage

`default_nettype wire

### hw/rtl/indexed_sequence_store.sv
// An accepted word passes a decode state, which reads the addressed cells,
// then an apply state, which waits while the output register holds an untaken
// result and then moves the whole cell row at once; only then is a new word taken.
// A finished result waits in the output register while the next word enters.
// Reset clears the element count and the handshake state; the cells are
// not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Bounded ordered sequence of signed words held in a row of shifting cells:
// push, insert, extract, pop and swap by position.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_sequence_store #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [iss_pkg::MODE_W-1:0]  mode,
    input  wire logic signed [iss_pkg::DATA_W-1:0]  value_in,
    input  wire logic        [iss_pkg::POSA_W-1:0]  position_a,
    input  wire logic        [iss_pkg::POSB_W-1:0]  position_b,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [iss_pkg::DATA_W-1:0]  value_out,
    output logic             [iss_pkg::STATUS_W-1:0] status,
    output logic             [iss_pkg::FILL_W-1:0]  fill_count
);

    import iss_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSA_W) ? CNT_W : POSA_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_SWAP
    } act_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [POSA_W-1:0]   pa_reg;
    logic [POSB_W-1:0]   pb_reg;

    act_t                act_reg;
    logic [IDX_W-1:0]    pos1_reg;
    logic [IDX_W-1:0]    pos2_reg;
    logic [DATA_W-1:0]   rd_a_reg;
    logic [DATA_W-1:0]   rd_b_reg;
    status_t             st_reg;

    logic                out_valid_reg;
    logic [DATA_W-1:0]   value_out_reg;
    status_t             status_reg;
    logic [FILL_W-1:0]   fill_reg;

    act_t                act_next;
    logic [IDX_W-1:0]    pos1_next;
    logic [IDX_W-1:0]    pos2_next;
    logic [DATA_W-1:0]   rd_a_next;
    logic [DATA_W-1:0]   rd_b_next;
    status_t             st_next;
    logic [CNT_W-1:0]    count_next;

    logic [CMP_W-1:0]    pa_c;
    logic [CMP_W-1:0]    pb_c;
    logic [CMP_W-1:0]    cnt_c;
    logic [CMP_W-1:0]    last_c;
    logic                is_full;
    logic                is_empty;
    logic                apply_go;

    logic [DATA_W-1:0]   cell_data [CAPACITY];
    cell_op_t            cell_op   [CAPACITY];
    logic [DATA_W-1:0]   load_a_data;
    logic [DATA_W-1:0]   load_b_data;

    // ---------------------------------------------------------------- decode
    always_comb
    begin
        pa_c     = CMP_W'(pa_reg);
        pb_c     = CMP_W'(pb_reg);
        cnt_c    = CMP_W'(count_reg);
        last_c   = cnt_c - CMP_W'(1);
        is_full  = (cnt_c == CMP_W'(CAPACITY));
        is_empty = (count_reg == '0);

        act_next  = ACT_NONE;
        st_next   = STATUS_OK;
        pos1_next = '0;
        pos2_next = pb_c[IDX_W-1:0];

        unique case (mode_reg)
            MODE_PUSH_HEAD:
            begin
                if (is_full)
                    st_next = STATUS_FULL;
                else
                    act_next = ACT_INSERT;
            end
            MODE_PUSH_TAIL:
            begin
                pos1_next = cnt_c[IDX_W-1:0];
                if (is_full)
                    st_next = STATUS_FULL;
                else
                    act_next = ACT_INSERT;
            end
            MODE_INSERT:
            begin
                pos1_next = pa_c[IDX_W-1:0];
                if (is_full)
                    st_next = STATUS_FULL;
                else if (pa_c > cnt_c)
                    st_next = STATUS_BADIDX;
                else
                    act_next = ACT_INSERT;
            end
            MODE_EXTRACT:
            begin
                pos1_next = pa_c[IDX_W-1:0];
                if (is_empty)
                    st_next = STATUS_EMPTY;
                else if (pa_c >= cnt_c)
                    st_next = STATUS_BADIDX;
                else
                    act_next = ACT_REMOVE;
            end
            MODE_POP_HEAD:
            begin
                if (is_empty)
                    st_next = STATUS_EMPTY;
                else
                    act_next = ACT_REMOVE;
            end
            MODE_POP_TAIL:
            begin
                pos1_next = last_c[IDX_W-1:0];
                if (is_empty)
                    st_next = STATUS_EMPTY;
                else
                    act_next = ACT_REMOVE;
            end
            MODE_SWAP:
            begin
                pos1_next = pa_c[IDX_W-1:0];
                if ((pa_c >= cnt_c) || (pb_c >= cnt_c))
                    st_next = STATUS_BADIDX;
                else
                    act_next = ACT_SWAP;
            end
            default:
            begin
                act_next = ACT_NONE;
            end
        endcase
    end

    // read buses: each cell drives its word when addressed
    always_comb
    begin
        rd_a_next = '0;
        rd_b_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pos1_next == IDX_W'(i))
                rd_a_next = rd_a_next | cell_data[i];
            if (pos2_next == IDX_W'(i))
                rd_b_next = rd_b_next | cell_data[i];
        end
    end

    // ----------------------------------------------------------------- apply
    assign apply_go = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_op[i] = CELL_HOLD;
            if (apply_go)
            begin
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        if (IDX_W'(i) == pos1_reg)
                            cell_op[i] = CELL_LOAD_A;
                        else if (IDX_W'(i) > pos1_reg)
                            cell_op[i] = CELL_LEFT;
                    end
                    ACT_REMOVE:
                    begin
                        if (IDX_W'(i) >= pos1_reg)
                            cell_op[i] = CELL_RIGHT;
                    end
                    ACT_SWAP:
                    begin
                        if (IDX_W'(i) == pos1_reg)
                            cell_op[i] = CELL_LOAD_A;
                        else if (IDX_W'(i) == pos2_reg)
                            cell_op[i] = CELL_LOAD_B;
                    end
                    default:
                    begin
                        cell_op[i] = CELL_HOLD;
                    end
                endcase
            end
        end
    end

    assign load_a_data = (act_reg == ACT_SWAP) ? rd_b_reg : value_reg;
    assign load_b_data = rd_a_reg;

    always_comb
    begin
        unique case (act_reg)
            ACT_INSERT: count_next = count_reg + CNT_W'(1);
            ACT_REMOVE: count_next = count_reg - CNT_W'(1);
            default:    count_next = count_reg;
        endcase
    end

    // ----------------------------------------------------------- cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_head
            assign left_w = '0;
        end
        else
        begin : g_body_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_w = cell_data[g];
        end
        else
        begin : g_body_r
            assign right_w = cell_data[g+1];
        end

        iss_cell u_cell (
            .clk         (clk),
            .op          (cell_op[g]),
            .left_data   (left_w),
            .right_data  (right_w),
            .load_a_data (load_a_data),
            .load_b_data (load_b_data),
            .data        (cell_data[g])
        );
    end

    // --------------------------------------------------------- control / out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            act_reg       <= ACT_NONE;
        end
        else
        begin
            // a new result takes the output register; otherwise drop a taken one
            if (apply_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        value_reg <= value_in;
                        pa_reg    <= position_a;
                        pb_reg    <= position_b;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    act_reg   <= act_next;
                    st_reg    <= st_next;
                    pos1_reg  <= pos1_next;
                    pos2_reg  <= pos2_next;
                    rd_a_reg  <= rd_a_next;
                    rd_b_reg  <= rd_b_next;
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    // hold until the output register is free
                    if (apply_go)
                    begin
                        count_reg     <= count_next;
                        value_out_reg <= (act_reg == ACT_REMOVE) ? rd_a_reg : '0;
                        status_reg    <= st_reg;
                        fill_reg      <= FILL_W'(count_next);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign value_out  = value_out_reg;
    assign status     = status_reg;
    assign fill_count = fill_reg;

endmodule

`default_nettype wire

### hw/rtl/iss_cell.sv
// ----------------------------------------------------------------------------
// iss_cell
// One element slot of the store: holds a word, or takes the word of its left
// or right neighbour, or one of two broadcast words.
// ----------------------------------------------------------------------------
`default_nettype none

module iss_cell (
    input  wire logic                         clk,
    input  wire iss_pkg::cell_op_t            op,
    input  wire logic [iss_pkg::DATA_W-1:0]   left_data,
    input  wire logic [iss_pkg::DATA_W-1:0]   right_data,
    input  wire logic [iss_pkg::DATA_W-1:0]   load_a_data,
    input  wire logic [iss_pkg::DATA_W-1:0]   load_b_data,
    output logic      [iss_pkg::DATA_W-1:0]   data
);

    import iss_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        unique case (op)
            CELL_LEFT:   data_next = left_data;
            CELL_RIGHT:  data_next = right_data;
            CELL_LOAD_A: data_next = load_a_data;
            CELL_LOAD_B: data_next = load_b_data;
            default:     data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### hw/rtl/iss_checker.sv
// ----------------------------------------------------------------------------
// iss_checker
// Port-level checks of the indexed sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_sequence_store_assert.svh"

module iss_checker #(
    parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic        [iss_pkg::MODE_W-1:0]  mode,
    input  wire logic signed [iss_pkg::DATA_W-1:0]  value_in,
    input  wire logic        [iss_pkg::POSA_W-1:0]  position_a,
    input  wire logic        [iss_pkg::POSB_W-1:0]  position_b,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic signed [iss_pkg::DATA_W-1:0]  value_out,
    input  wire logic        [iss_pkg::STATUS_W-1:0] status,
    input  wire logic        [iss_pkg::FILL_W-1:0]  fill_count
);

    import iss_pkg::*;

    logic in_fire;
    logic in_seen;

    assign in_fire = in_valid && in_ready;
    // payload ports are watched only through the handshake
    assign in_seen = in_fire && ((mode != '0) || (value_in != '0) ||
                                 (position_a != '0) || (position_b != '0) || 1'b1);

    `ISS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(value_out) && $stable(status) && $stable(fill_count),
        "stalled result word changed")

    `ISS_ASSERT_NEXT(a_busy_after_accept, in_seen, !in_ready,
        "input taken again straight after a word")

    `ISS_ASSERT_NOW(a_empty_count, out_valid && (status == STATUS_EMPTY),
        fill_count == '0, "empty status with a non-zero count")

    `ISS_ASSERT_NOW(a_full_count, out_valid && (status == STATUS_FULL),
        fill_count == FILL_W'(CAPACITY), "full status below capacity")

    `ISS_ASSERT_NOW(a_fail_zero, out_valid && (status != STATUS_OK),
        value_out == '0, "failed operation returned a word")

endmodule

bind indexed_sequence_store iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (.*);

`default_nettype wire
